// ===== hdl/dpps_pkg.sv =====
package dpps_pkg;

    localparam int FOG_STEPS     = 8;
    localparam int SKY_SPAN_BASE = 84;

    localparam int FOG_LAST = FOG_STEPS - 1;
    localparam int SKY_DIV  = SKY_SPAN_BASE + 40;

    localparam int MODE_W   = 2;
    localparam int COLOR_W  = 6;
    localparam int FOG_W    = 7;
    localparam int ROW_W    = 8;
    localparam int COL_W    = 8;
    localparam int PIXEL_W  = 8;

    localparam logic [7:0] FOG_MAX = 8'(FOG_LAST * 16);
    localparam logic [PIXEL_W-1:0] OPAQUE = 8'hC0;

    localparam logic [COLOR_W-1:0] EMISSIVE_WHITE  = 6'd63;
    localparam logic [COLOR_W-1:0] EMISSIVE_YELLOW = 6'd60;

    localparam int HOR_R = 170;
    localparam int HOR_G = 170;
    localparam int HOR_B = 255;
    localparam int TOP_R = 0;
    localparam int TOP_G = 85;
    localparam int TOP_B = 255;

    typedef enum logic [MODE_W-1:0] {
        MODE_TERRAIN = 2'd0,
        MODE_SKY     = 2'd1,
        MODE_SHADOW  = 2'd2,
        MODE_HUD     = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t               mode;
        logic [COLOR_W-1:0]  pixel_color;
        logic [FOG_W-1:0]    fog_fraction;
        logic [ROW_W-1:0]    screen_row;
        logic [COL_W-1:0]    screen_col;
    } pix_in_t;

    // 4x4 ordered dither, index {row[1:0], col[1:0]}
    typedef logic [3:0] bayer_t [16];
    localparam bayer_t BAYER = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    // fog blend of one 2-bit channel, index {level[3:0], channel[1:0]}
    typedef logic [1:0] fog_lut_t [64];

    function automatic fog_lut_t make_fog_lut(input int hor);
        fog_lut_t lut;
        int       lvl;
        int       c;
        int       t;
        int       v;
        for (int i = 0; i < 64; i++)
        begin
            lvl = i >> 2;
            c   = i & 3;
            t   = (lvl * 255) / FOG_LAST;
            v   = c + (((hor - c) * t + 128) >>> 8);
            if (v < 0)
            begin
                v = 0;
            end
            if (v > 3)
            begin
                v = 3;
            end
            lut[i] = 2'(v);
        end
        return lut;
    endfunction

    localparam fog_lut_t FOG_LUT_RG = make_fog_lut(HOR_R >> 6);
    localparam fog_lut_t FOG_LUT_B  = make_fog_lut(HOR_B >> 6);

    // sky gradient per row: three channels scaled to 0..48, {r, g, b}
    typedef logic [17:0] sky_lut_t [256];

    function automatic int to_ch16(input int v255);
        int v;
        v = (v255 * 48) / 255;
        return (v > 48) ? 48 : v;
    endfunction

    function automatic sky_lut_t make_sky_lut();
        sky_lut_t lut;
        int       t;
        int       r;
        int       g;
        int       b;
        for (int row = 0; row < 256; row++)
        begin
            t = (row * 255) / SKY_DIV;
            if (t > 255)
            begin
                t = 255;
            end
            r = to_ch16(TOP_R + (((HOR_R - TOP_R) * t) >> 8));
            g = to_ch16(TOP_G + (((HOR_G - TOP_G) * t) >> 8));
            b = to_ch16(TOP_B + (((HOR_B - TOP_B) * t) >> 8));
            lut[row] = {6'(r), 6'(g), 6'(b)};
        end
        return lut;
    endfunction

    localparam sky_lut_t SKY_LUT = make_sky_lut();

endpackage

// ===== hdl/dpps_pix_in_if.sv =====
interface dpps_pix_in_if;
    import dpps_pkg::*;

    logic                valid;
    logic                ready;
    mode_t               mode;
    logic [COLOR_W-1:0]  pixel_color;
    logic [FOG_W-1:0]    fog_fraction;
    logic [ROW_W-1:0]    screen_row;
    logic [COL_W-1:0]    screen_col;

    modport source
    (
        output valid, mode, pixel_color, fog_fraction, screen_row, screen_col,
        input  ready
    );

    modport sink
    (
        input  valid, mode, pixel_color, fog_fraction, screen_row, screen_col,
        output ready
    );
endinterface

// ===== hdl/dpps_pix_out_if.sv =====
interface dpps_pix_out_if;
    import dpps_pkg::*;

    logic                valid;
    logic                ready;
    logic [PIXEL_W-1:0]  pixel_out;

    modport source
    (
        output valid, pixel_out,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_out,
        output ready
    );
endinterface

// ===== hdl/dpps_shade.sv =====
module dpps_shade
(
    input  dpps_pkg::pix_in_t              pix,
    output logic [dpps_pkg::PIXEL_W-1:0]   pixel
);
    import dpps_pkg::*;

    function automatic logic [1:0] dec_sat(input logic [1:0] c);
        return (c == 2'd0) ? 2'd0 : c - 2'd1;
    endfunction

    function automatic logic [COLOR_W-1:0] darken(input logic [COLOR_W-1:0] c);
        return {dec_sat(c[5:4]), dec_sat(c[3:2]), dec_sat(c[1:0])};
    endfunction

    // ordered dither of a 0..48 channel, saturating at 3
    function automatic logic [1:0] sky_q(input logic [5:0] lvl, input logic [3:0] bay);
        logic [6:0] sum;
        sum = 7'(lvl) + 7'(bay);
        return (sum[6:4] > 3'd3) ? 2'd3 : sum[5:4];
    endfunction

    logic [3:0]         bay;
    logic [7:0]         fog_ext;
    logic [7:0]         fog_c;
    logic [3:0]         lvl_lo;
    logic [3:0]         lvl_hi;
    logic [3:0]         lvl;
    logic [4:0]         thr;
    logic [COLOR_W-1:0] fog_res;
    logic [17:0]        sky_e;
    logic [COLOR_W-1:0] sky_res;
    logic [COLOR_W-1:0] res;

    always_comb
    begin
        bay = BAYER[{pix.screen_row[1:0], pix.screen_col[1:0]}];

        // terrain: pick fog level per dither cell
        fog_ext = {1'b0, pix.fog_fraction};
        fog_c   = (fog_ext > FOG_MAX) ? FOG_MAX : fog_ext;
        lvl_lo  = fog_c[7:4];
        thr     = 5'd16 - {1'b0, fog_c[3:0]};
        lvl_hi  = ((5'(lvl_lo) + 5'd1) < 5'(FOG_STEPS)) ? lvl_lo + 4'd1 : lvl_lo;
        lvl     = ({1'b0, bay} >= thr) ? lvl_hi : lvl_lo;

        if (pix.pixel_color == EMISSIVE_WHITE || pix.pixel_color == EMISSIVE_YELLOW)
        begin
            fog_res = pix.pixel_color;
        end
        else
        begin
            fog_res = {FOG_LUT_RG[{lvl, pix.pixel_color[5:4]}],
                       FOG_LUT_RG[{lvl, pix.pixel_color[3:2]}],
                       FOG_LUT_B[{lvl, pix.pixel_color[1:0]}]};
        end

        sky_e   = SKY_LUT[pix.screen_row];
        sky_res = {sky_q(sky_e[17:12], bay), sky_q(sky_e[11:6], bay),
                   sky_q(sky_e[5:0], bay)};

        unique case (pix.mode)
            MODE_TERRAIN: res = fog_res;
            MODE_SKY:     res = sky_res;
            MODE_SHADOW:  res = bay[3] ? darken(pix.pixel_color) : pix.pixel_color;
            MODE_HUD:     res = darken(darken(pix.pixel_color));
            default:      res = pix.pixel_color;
        endcase

        pixel = OPAQUE | {2'b00, res};
    end
endmodule

// ===== hdl/dithered_palette_pixel_shader.sv =====
// Ordered-dither palette shader, one pixel per transfer.
// Stages: input reg, result reg; all shading is table lookups and narrow adds in one stage.
// Throughput: 1 pixel per cycle unless pix_out.ready is held low.
// Reset (rst_n low, asynchronous): both stages empty; no tables or state need clearing.
module dithered_palette_pixel_shader
(
    input  logic            clk,
    input  logic            rst_n,
    dpps_pix_in_if.sink     pix_in,
    dpps_pix_out_if.source  pix_out
);
    import dpps_pkg::*;

    pix_in_t             in_reg;
    logic                in_valid_reg;
    logic [PIXEL_W-1:0]  pixel_reg;
    logic                out_valid_reg;
    logic [PIXEL_W-1:0]  pixel_next;
    logic                out_adv;
    logic                in_adv;

    dpps_shade u_shade
    (
        .pix   (in_reg),
        .pixel (pixel_next)
    );

    // result stage refills when empty or its pixel is being taken
    assign out_adv      = !out_valid_reg || pix_out.ready;
    assign in_adv       = !in_valid_reg || out_adv;
    assign pix_in.ready = in_adv;

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.pixel_out = pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
            begin
                in_valid_reg <= pix_in.valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && pix_in.valid)
        begin
            in_reg.mode         <= pix_in.mode;
            in_reg.pixel_color  <= pix_in.pixel_color;
            in_reg.fog_fraction <= pix_in.fog_fraction;
            in_reg.screen_row   <= pix_in.screen_row;
            in_reg.screen_col   <= pix_in.screen_col;
        end
        if (out_adv && in_valid_reg)
        begin
            pixel_reg <= pixel_next;
        end
    end
endmodule
